@@ rtl/sesst_pkg.sv @@
// Shared types and constants for the session table with an address pool.
// Used by sesst_cell, sesst_ctrl and the top level session_table_with_ip_pool.
package sesst_pkg;

  localparam int UE_W      = 40;
  localparam int SID_W     = 8;
  localparam int STYPE_W   = 8;
  localparam int SDIFF_W   = 24;
  localparam int ADDR_W    = 32;
  localparam int TUNNEL_W  = 32;
  localparam int FUNC_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 6;
  localparam int ACTIVE_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_CREATE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIND    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST  = 1'b1;

  localparam logic [ADDR_W-1:0]   POOL_FIRST_RESET = 32'h0A00_0001;
  localparam logic [ADDR_W-1:0]   POOL_LAST_RESET  = 32'h0A00_00FE;
  localparam logic [TUNNEL_W-1:0] TUNNEL_FACTOR    = 32'd1000;

  typedef struct packed {
    logic               valid;
    logic [UE_W-1:0]    ue;
    logic [SID_W-1:0]   session;
    logic [STYPE_W-1:0] slice_type;
    logic [SDIFF_W-1:0] slice_diff;
    logic [ADDR_W-1:0]  address;
    logic [TUNNEL_W-1:0] tunnel;
  } entry_t;

  typedef struct packed {
    logic   shift;
    entry_t tail;
  } ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/sesst_cell.sv @@
// One slot of the rotating session ring: holds an entry and takes its neighbor's
// entry on every shift. Depends on sesst_pkg.
module sesst_cell
  import sesst_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t shift_in,
  output entry_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q <= shift_in;
    end
  end

endmodule

@@ rtl/sesst_ctrl.sv @@
// Request sequencer: walks the ring head over one full turn, acts on the first
// free or matching slot, keeps the address pool and drives the result register.
// Depends on sesst_pkg.
module sesst_ctrl
  import sesst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [FUNC_W-1:0]      func,
  input  logic [UE_W-1:0]        ue_id,
  input  logic [SID_W-1:0]       session_id,
  input  logic [STYPE_W-1:0]     slice_type,
  input  logic [SDIFF_W-1:0]     slice_diff,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    status,
  output logic [SLOT_W-1:0]      slot_index,
  output logic [ADDR_W-1:0]      ue_address,
  output logic [TUNNEL_W-1:0]    tunnel_id,
  output logic [STYPE_W-1:0]     stored_slice_type,
  output logic [SDIFF_W-1:0]     stored_slice_diff,
  output logic [ACTIVE_W-1:0]    active_count,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  entry_t                 head,
  output ring_ctl_t              ring_ctl
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [FUNC_W-1:0]   func_r;
  logic [UE_W-1:0]     ue_r;
  logic [SID_W-1:0]    sid_r;
  logic [STYPE_W-1:0]  stype_r;
  logic [SDIFF_W-1:0]  sdiff_r;
  logic [TUNNEL_W-1:0] tunnel_r;
  logic [TUNNEL_W-1:0] tunnel_prod;
  logic [IDX_W-1:0]    step;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   pool_first;
  logic [ADDR_W-1:0]   pool_last;
  logic [ADDR_W-1:0]   next_address;
  logic [ADDR_W-1:0]   addr_inc;

  logic                hit;
  logic [IDX_W-1:0]    res_slot;
  logic [ADDR_W-1:0]   res_addr;
  logic [TUNNEL_W-1:0] res_tunnel;
  logic [STYPE_W-1:0]  res_stype;
  logic [SDIFF_W-1:0]  res_sdiff;

  logic head_free, head_match, act;
  logic is_create, is_release, is_find;
  logic in_fire, out_load;
  entry_t new_entry;
  logic [IDX_W+SLOT_W-1:0]   slot_ext;
  logic [CNT_W+ACTIVE_W-1:0] count_ext;

  assign is_create  = (func_r == FUNC_CREATE);
  assign is_release = (func_r == FUNC_RELEASE);
  assign is_find    = (func_r == FUNC_FIND);
  assign head_free  = !head.valid;
  assign head_match = head.valid && (head.ue == ue_r) && (head.session == sid_r);
  assign act = (state == ST_SCAN) && !hit &&
               ((is_create && head_free) || ((is_release || is_find) && head_match));
  assign tunnel_prod = ue_r[TUNNEL_W-1:0] * TUNNEL_FACTOR;
  assign addr_inc    = next_address + ADDR_W'(1);
  assign in_fire     = in_valid && in_ready;
  assign out_load    = (state == ST_FINISH) && (!out_valid || out_ready);
  assign slot_ext    = {{SLOT_W{1'b0}}, res_slot};
  assign count_ext   = {{ACTIVE_W{1'b0}}, count};

  always_comb begin
    new_entry            = head;
    new_entry.valid      = 1'b1;
    new_entry.ue         = ue_r;
    new_entry.session    = sid_r;
    new_entry.slice_type = stype_r;
    new_entry.slice_diff = sdiff_r;
    new_entry.address    = next_address;
    new_entry.tunnel     = tunnel_r;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire) state_next = ST_CALC;
      ST_CALC:   state_next = ST_SCAN;
      ST_SCAN:   if (step == LAST_STEP) state_next = ST_FINISH;
      ST_FINISH: if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    ring_ctl.shift = (state == ST_SCAN);
    ring_ctl.tail  = head;
    if (act && is_create) begin
      ring_ctl.tail = new_entry;
    end else if (act && is_release) begin
      ring_ctl.tail.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= func;
      ue_r    <= ue_id;
      sid_r   <= session_id;
      stype_r <= slice_type;
      sdiff_r <= slice_diff;
    end
    if (state == ST_CALC) begin
      tunnel_r   <= tunnel_prod + TUNNEL_W'(sid_r);
      step       <= '0;
      res_slot   <= '0;
      res_addr   <= '0;
      res_tunnel <= '0;
      res_stype  <= '0;
      res_sdiff  <= '0;
    end
    if (state == ST_SCAN) begin
      step <= step + IDX_W'(1);
    end
    if (act) begin
      res_slot <= step;
      if (is_create) begin
        res_addr   <= next_address;
        res_tunnel <= tunnel_r;
        res_stype  <= stype_r;
        res_sdiff  <= sdiff_r;
      end else if (is_find) begin
        res_addr   <= head.address;
        res_tunnel <= head.tunnel;
        res_stype  <= head.slice_type;
        res_sdiff  <= head.slice_diff;
      end
    end
    if (out_load) begin
      if (hit) begin
        status <= STATUS_OK;
      end else if (is_create) begin
        status <= STATUS_FULL;
      end else begin
        status <= STATUS_NOT_FOUND;
      end
      slot_index        <= slot_ext[SLOT_W-1:0];
      ue_address        <= res_addr;
      tunnel_id         <= res_tunnel;
      stored_slice_type <= res_stype;
      stored_slice_diff <= res_sdiff;
      active_count      <= count_ext[ACTIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit          <= 1'b0;
      count        <= '0;
      out_valid    <= 1'b0;
      pool_first   <= POOL_FIRST_RESET;
      pool_last    <= POOL_LAST_RESET;
      next_address <= POOL_FIRST_RESET;
    end else begin
      if (state == ST_CALC) begin
        hit <= 1'b0;
      end
      if (act) begin
        hit <= 1'b1;
        if (is_create) begin
          count <= count + CNT_W'(1);
          if (addr_inc > pool_last) begin
            next_address <= pool_first;
          end else begin
            next_address <= addr_inc;
          end
        end else if (is_release) begin
          count <= count - CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POOL_FIRST: begin
            pool_first   <= cfg_data;
            next_address <= cfg_data;
          end
          CFG_POOL_LAST: pool_last <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/session_table_with_ip_pool.sv @@
// Top level of the session table: a ring of sesst_cell slots rotated by sesst_ctrl.
// Depends on sesst_pkg, sesst_cell and sesst_ctrl.
//
//   Port group  Direction  Handshake            Payload
//   request     in         in_valid / in_ready  func, ue_id, session_id, slice_type, slice_diff
//   result      out        out_valid/out_ready  status .. active_count
//   config      in         cfg_we               cfg_index, cfg_data
//
// Each request passes through the tunnel multiply, then one full turn of the ring, one slot per
// cycle past the head cell, then the load of the result register, before the result beat
// is offered.
// Reset clears all valid bits at once and loads the pool registers; no sweep is needed.
// A stalled result holds the sequencer in its final state; the next request is taken
// once that result is loaded, even if it has not yet been taken.
module session_table_with_ip_pool
  import sesst_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    func,
  input  logic [UE_W-1:0]      ue_id,
  input  logic [SID_W-1:0]     session_id,
  input  logic [STYPE_W-1:0]   slice_type,
  input  logic [SDIFF_W-1:0]   slice_diff,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    slot_index,
  output logic [ADDR_W-1:0]    ue_address,
  output logic [TUNNEL_W-1:0]  tunnel_id,
  output logic [STYPE_W-1:0]   stored_slice_type,
  output logic [SDIFF_W-1:0]   stored_slice_diff,
  output logic [ACTIVE_W-1:0]  active_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  entry_t    ring [TABLE_ENTRIES];
  ring_ctl_t ring_ctl;

  sesst_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .func              (func),
    .ue_id             (ue_id),
    .session_id        (session_id),
    .slice_type        (slice_type),
    .slice_diff        (slice_diff),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .slot_index        (slot_index),
    .ue_address        (ue_address),
    .tunnel_id         (tunnel_id),
    .stored_slice_type (stored_slice_type),
    .stored_slice_diff (stored_slice_diff),
    .active_count      (active_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .head              (ring[0]),
    .ring_ctl          (ring_ctl)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      sesst_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ring_ctl.shift),
        .shift_in (ring_ctl.tail),
        .q        (ring[i])
      );
    end else begin : g_body
      sesst_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (ring_ctl.shift),
        .shift_in (ring[i+1]),
        .q        (ring[i])
      );
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for session_table_with_ip_pool: a directed script,
// then random create, release, find and unused-function traffic under several pool settings.
// Depends on sesst_pkg and the session_table_with_ip_pool RTL.
module tb_top;
  import sesst_pkg::*;

  localparam int SLOTS = 64;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [TUNNEL_W-1:0] TUNNEL_SCALE = 32'd1000;
  localparam logic [ADDR_W-1:0] FIRST_AT_RESET = 32'h0A00_0001;
  localparam logic [ADDR_W-1:0] LAST_AT_RESET = 32'h0A00_00FE;
  localparam logic [UE_W-1:0] UE_MAX = '1;

  typedef struct packed {
    logic [FUNC_W-1:0]  op;
    logic [UE_W-1:0]    ue;
    logic [SID_W-1:0]   sid;
    logic [STYPE_W-1:0] stype;
    logic [SDIFF_W-1:0] sdiff;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   address;
    logic [TUNNEL_W-1:0] tunnel;
    logic [STYPE_W-1:0]  stype;
    logic [SDIFF_W-1:0]  sdiff;
    logic [ACTIVE_W-1:0] active;
  } session_result_t;

  typedef struct {
    request_t        req;
    bit              typed;
    session_result_t want;
  } script_row_t;

  typedef struct {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    bit                set_first;
    bit                set_last;
    bit                quiet;
  } pool_setting_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [FUNC_W-1:0]    func;
  logic [UE_W-1:0]      ue_id;
  logic [SID_W-1:0]     session_id;
  logic [STYPE_W-1:0]   slice_type;
  logic [SDIFF_W-1:0]   slice_diff;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot_index;
  logic [ADDR_W-1:0]    ue_address;
  logic [TUNNEL_W-1:0]  tunnel_id;
  logic [STYPE_W-1:0]   stored_slice_type;
  logic [SDIFF_W-1:0]   stored_slice_diff;
  logic [ACTIVE_W-1:0]  active_count;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  session_table_with_ip_pool #(.TABLE_ENTRIES(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .ue_id(ue_id), .session_id(session_id),
    .slice_type(slice_type), .slice_diff(slice_diff),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_index(slot_index), .ue_address(ue_address),
    .tunnel_id(tunnel_id), .stored_slice_type(stored_slice_type),
    .stored_slice_diff(stored_slice_diff), .active_count(active_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the session table and the address pool.
  bit                  tbl_valid [SLOTS];
  logic [UE_W-1:0]     tbl_ue [SLOTS];
  logic [SID_W-1:0]    tbl_sid [SLOTS];
  logic [STYPE_W-1:0]  tbl_stype [SLOTS];
  logic [SDIFF_W-1:0]  tbl_sdiff [SLOTS];
  logic [ADDR_W-1:0]   tbl_addr [SLOTS];
  logic [TUNNEL_W-1:0] tbl_tunnel [SLOTS];
  logic [ADDR_W-1:0]   pool_first;
  logic [ADDR_W-1:0]   pool_last;
  logic [ADDR_W-1:0]   next_addr;
  int                  live;

  session_result_t results_due[$];
  script_row_t     script[$];
  pool_setting_t   plan [PHASES];
  int              failures = 0;
  int              cycle_count = 0;
  int              stall_left = 0;
  bit              calm = 1'b0;

  function automatic int find_slot(logic [UE_W-1:0] ue, logic [SID_W-1:0] sid);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_ue[i] == ue && tbl_sid[i] == sid) return i;
    end
    return -1;
  endfunction

  function automatic session_result_t entry_result(int s);
    session_result_t r;
    r = '0;
    r.status = STATUS_OK;
    r.slot = SLOT_W'(s);
    r.address = tbl_addr[s];
    r.tunnel = tbl_tunnel[s];
    r.stype = tbl_stype[s];
    r.sdiff = tbl_sdiff[s];
    return r;
  endfunction

  function automatic session_result_t apply_request(request_t q);
    session_result_t r;
    int s;
    r = '0;
    r.status = STATUS_NOT_FOUND;
    s = -1;
    case (q.op)
      FUNC_CREATE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i] && s < 0) s = i;
        end
        if (s < 0) begin
          r.status = STATUS_FULL;
        end else begin
          tbl_valid[s] = 1'b1;
          tbl_ue[s] = q.ue;
          tbl_sid[s] = q.sid;
          tbl_stype[s] = q.stype;
          tbl_sdiff[s] = q.sdiff;
          tbl_addr[s] = next_addr;
          tbl_tunnel[s] = q.ue[31:0] * TUNNEL_SCALE + TUNNEL_W'(q.sid);
          next_addr = next_addr + 32'd1;
          if (next_addr > pool_last) next_addr = pool_first;
          live++;
          r = entry_result(s);
        end
      end
      FUNC_RELEASE: begin
        s = find_slot(q.ue, q.sid);
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          live--;
          r.status = STATUS_OK;
          r.slot = SLOT_W'(s);
        end
      end
      FUNC_FIND: begin
        s = find_slot(q.ue, q.sid);
        if (s >= 0) r = entry_result(s);
      end
      default: begin
      end
    endcase
    r.active = ACTIVE_W'(live);
    return r;
  endfunction

  function automatic session_result_t miss(int act);
    session_result_t r;
    r = '0;
    r.status = STATUS_NOT_FOUND;
    r.active = ACTIVE_W'(act);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 100);
  endfunction

  function automatic bit pick_live(output logic [UE_W-1:0] ue, output logic [SID_W-1:0] sid);
    int start;
    int i;
    start = $urandom_range(0, SLOTS - 1);
    ue = '0;
    sid = '0;
    for (int k = 0; k < SLOTS; k++) begin
      i = (start + k) % SLOTS;
      if (tbl_valid[i]) begin
        ue = tbl_ue[i];
        sid = tbl_sid[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic request_t random_item(bit grow);
    request_t q;
    int r;
    int wcreate;
    int wrelease;
    logic [UE_W-1:0] ue;
    logic [SID_W-1:0] sid;
    q.ue = {8'($urandom), 32'($urandom)};
    if ($urandom_range(0, 9) == 0) q.ue = UE_W'($urandom_range(0, 3));
    else if ($urandom_range(0, 19) == 0) q.ue = UE_MAX;
    q.sid = SID_W'($urandom);
    q.stype = STYPE_W'($urandom);
    q.sdiff = SDIFF_W'($urandom);
    wcreate = grow ? 70 : 10;
    wrelease = grow ? 10 : 60;
    r = $urandom_range(0, 99);
    if (r < 4) q.op = FUNC_UNUSED;
    else if (r < 4 + wcreate) q.op = FUNC_CREATE;
    else if (r < 4 + wcreate + wrelease) q.op = FUNC_RELEASE;
    else q.op = FUNC_FIND;
    r = $urandom_range(0, 99);
    if ((q.op == FUNC_CREATE) ? (r < 8) : (r < 90)) begin
      if (pick_live(ue, sid)) begin
        q.ue = ue;
        q.sid = sid;
        if (q.op != FUNC_CREATE && r >= 84) begin
          if ($urandom_range(0, 1) == 1) begin
            ue = q.ue;
            ue[$urandom_range(0, UE_W - 1)] = ~ue[$urandom_range(0, UE_W - 1)];
            q.ue = ue ^ UE_W'(1);
          end else begin
            q.sid = q.sid ^ SID_W'(1 << $urandom_range(0, SID_W - 1));
          end
        end
      end
    end
    return q;
  endfunction

  // Present one request and hold it until the block takes the beat.
  task automatic offer(request_t q, bit typed, session_result_t want);
    session_result_t p;
    in_valid <= 1'b1;
    func <= q.op;
    ue_id <= q.ue;
    session_id <= q.sid;
    slice_type <= q.stype;
    slice_diff <= q.sdiff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = apply_request(q);
    results_due.push_back(typed ? want : p);
  endtask

  task automatic pause_sender();
    int gap;
    bit drain;
    gap = calm ? 0 : pick_gap();
    drain = ($urandom_range(0, 99) == 0);
    if (gap > 0 || drain) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    if (drain) begin
      while (results_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic set_pool(pool_setting_t c);
    if (c.set_last) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_POOL_LAST;
      cfg_data <= c.last;
      @(posedge clk);
      pool_last = c.last;
    end
    if (c.set_first) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_POOL_FIRST;
      cfg_data <= c.first;
      @(posedge clk);
      pool_first = c.first;
      next_addr = c.first;
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    session_result_t seen;
    session_result_t want;
    if (!rst && out_valid && out_ready) begin
      seen = '{status, slot_index, ue_address, tunnel_id, stored_slice_type,
               stored_slice_diff, active_count};
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: st=%0d slot=%0d addr=%h tun=%h type=%h diff=%h act=%0d",
                   seen.status, seen.slot, seen.address, seen.tunnel, seen.stype,
                   seen.sdiff, seen.active);
        end
      end else begin
        want = results_due.pop_front();
        if (seen !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("mismatch at cycle %0d:", cycle_count);
            $display("  expected st=%0d slot=%0d addr=%h tun=%h type=%h diff=%h act=%0d",
                     want.status, want.slot, want.address, want.tunnel, want.stype,
                     want.sdiff, want.active);
            $display("  actual   st=%0d slot=%0d addr=%h tun=%h type=%h diff=%h act=%0d",
                     seen.status, seen.slot, seen.address, seen.tunnel, seen.stype,
                     seen.sdiff, seen.active);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] base;
    rst = 1'b1;
    in_valid = 1'b0;
    func = '0;
    ue_id = '0;
    session_id = '0;
    slice_type = '0;
    slice_diff = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_ue[i] = '0;
      tbl_sid[i] = '0;
      tbl_stype[i] = '0;
      tbl_sdiff[i] = '0;
      tbl_addr[i] = '0;
      tbl_tunnel[i] = '0;
    end
    pool_first = FIRST_AT_RESET;
    pool_last = LAST_AT_RESET;
    next_addr = FIRST_AT_RESET;
    live = 0;

    script.push_back('{'{FUNC_FIND, 40'd0, 8'd0, 8'd0, 24'd0}, 1'b1, miss(0)});
    script.push_back('{'{FUNC_RELEASE, UE_MAX, 8'hFF, 8'hFF, 24'hFFFFFF}, 1'b1, miss(0)});
    script.push_back('{'{FUNC_UNUSED, 40'd0, 8'd0, 8'd0, 24'd0}, 1'b1, miss(0)});
    script.push_back('{'{FUNC_CREATE, 40'd0, 8'd0, 8'd0, 24'd0}, 1'b1,
                       '{STATUS_OK, 6'd0, FIRST_AT_RESET, 32'd0, 8'd0, 24'd0, 7'd1}});
    script.push_back('{'{FUNC_CREATE, UE_MAX, 8'hFF, 8'hFF, 24'hFFFFFF}, 1'b1,
                       '{STATUS_OK, 6'd1, 32'h0A00_0002, 32'hFFFF_FD17, 8'hFF, 24'hFFFFFF,
                         7'd2}});
    script.push_back('{'{FUNC_FIND, UE_MAX, 8'hFF, 8'd0, 24'd0}, 1'b1,
                       '{STATUS_OK, 6'd1, 32'h0A00_0002, 32'hFFFF_FD17, 8'hFF, 24'hFFFFFF,
                         7'd2}});
    script.push_back('{'{FUNC_CREATE, 40'd0, 8'd0, 8'h5A, 24'h123456}, 1'b0, '0});
    script.push_back('{'{FUNC_FIND, 40'd0, 8'd0, 8'hFF, 24'hFFFFFF}, 1'b0, '0});
    script.push_back('{'{FUNC_RELEASE, 40'd0, 8'd0, 8'd0, 24'd0}, 1'b1,
                       '{STATUS_OK, 6'd0, 32'd0, 32'd0, 8'd0, 24'd0, 7'd2}});
    script.push_back('{'{FUNC_FIND, 40'd0, 8'd0, 8'd0, 24'd0}, 1'b0, '0});
    script.push_back('{'{FUNC_CREATE, 40'h55_5555_5555, 8'hAA, 8'hA5, 24'h5A5A5A}, 1'b0, '0});
    script.push_back('{'{FUNC_RELEASE, 40'd0, 8'd1, 8'd0, 24'd0}, 1'b1, miss(3)});
    script.push_back('{'{FUNC_UNUSED, UE_MAX, 8'hFF, 8'hFF, 24'hFFFFFF}, 1'b1, miss(3)});
    script.push_back('{'{FUNC_FIND, 40'hAA_AAAA_AAAA, 8'h55, 8'd0, 24'd0}, 1'b1, miss(3)});
    script.push_back('{'{FUNC_CREATE, 40'h00_FFFF_FFFF, 8'h01, 8'h80, 24'h800000}, 1'b0, '0});
    script.push_back('{'{FUNC_FIND, 40'h00_FFFF_FFFF, 8'h01, 8'd0, 24'd0}, 1'b0, '0});
    script.push_back('{'{FUNC_RELEASE, UE_MAX, 8'hFF, 8'd0, 24'd0}, 1'b1,
                       '{STATUS_OK, 6'd1, 32'd0, 32'd0, 8'd0, 24'd0, 7'd3}});
    script.push_back('{'{FUNC_RELEASE, UE_MAX, 8'hFF, 8'd0, 24'd0}, 1'b1, miss(3)});
    script.push_back('{'{FUNC_FIND, 40'h55_5555_5555, 8'hAB, 8'd0, 24'd0}, 1'b1, miss(3)});
    script.push_back('{'{FUNC_FIND, 40'h55_5555_5554, 8'hAA, 8'd0, 24'd0}, 1'b1, miss(3)});

    base = ADDR_W'($urandom);
    plan[0] = '{32'hC0A8_0001, 32'hC0A8_0004, 1'b1, 1'b1, 1'b0};
    plan[1] = '{32'd0, 32'h0A00_0003, 1'b0, 1'b1, 1'b1};
    plan[2] = '{32'd0, 32'd0, 1'b1, 1'b1, 1'b0};
    plan[3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0};
    plan[4] = '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1};
    plan[5] = '{32'h0000_0100, 32'h0000_0010, 1'b1, 1'b1, 1'b0};
    plan[6] = '{base, base + ADDR_W'($urandom_range(0, 40)), 1'b1, 1'b1, 1'b0};
    plan[7] = '{FIRST_AT_RESET, LAST_AT_RESET, 1'b1, 1'b1, 1'b0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      offer(script[k].req, script[k].typed, script[k].want);
      pause_sender();
    end

    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clk);
      calm = plan[p].quiet;
      set_pool(plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        offer(random_item(n < PHASE_ITEMS * 2 / 3), 1'b0, '0);
        pause_sender();
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
